// File: hdl/cpf_check_digit_validator_assert.svh
// Assertion macros for the CPF check-digit validator.
`ifndef CPF_CHECK_DIGIT_VALIDATOR_ASSERT_SVH
`define CPF_CHECK_DIGIT_VALIDATOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define CPF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CPF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CPF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CPF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: hdl/cpf_pkg.sv
package cpf_pkg;

  localparam int NUM_W    = 37;
  localparam int DIGITS   = 11;
  localparam int BCD_W    = 4 * DIGITS;
  localparam int SUM_W    = 10;
  localparam logic [NUM_W-1:0] MAX_VALUE = 37'd99999999999;

  // One beat moving down the conversion chain.
  typedef struct packed {
    logic             bad;
    logic [BCD_W-1:0] bcd;
    logic [NUM_W-1:0] bin;
  } dd_t;

  // x mod 11 for x < 1024: reciprocal estimate, then one correction.
  function automatic logic [3:0] mod11(input logic [SUM_W-1:0] x);
    logic [17:0]      p;
    logic [6:0]       q;
    logic [SUM_W-1:0] t;
    p = 18'(x) * 18'd186;
    q = p[17:11];
    t = x - ({3'b000, q} * 10'd11);
    if (t >= 10'd11) begin
      t = t - 10'd11;
    end
    return t[3:0];
  endfunction

  // Expected check digit from a weighted sum.
  function automatic logic [3:0] exp_digit(input logic [SUM_W-1:0] s);
    logic [3:0] r;
    r = mod11(s);
    return (r < 4'd2) ? 4'd0 : (4'd11 - r);
  endfunction

endpackage

// File: hdl/cpf_cell.sv
// One double-dabble step: adjust each digit, shift in the next binary bit.
module cpf_cell
  import cpf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  dd_t  in_data_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output dd_t  out_data_o,
  input  logic out_ready_i
);

  logic             valid_q, valid_d;
  dd_t              data_q, data_d;
  logic [BCD_W-1:0] adj;
  logic             en;

  assign en         = !valid_q || out_ready_i;
  assign in_ready_o = en;
  assign valid_d    = en ? in_valid_i : valid_q;

  always_comb begin
    adj = in_data_i.bcd;
    for (int i = 0; i < DIGITS; i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    data_d.bad = in_data_i.bad;
    data_d.bcd = {adj[BCD_W-2:0], in_data_i.bin[NUM_W-1]};
    data_d.bin = {in_data_i.bin[NUM_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// File: hdl/cpf_check.sv
`include "cpf_check_digit_validator_assert.svh"

// Weighted sums, then first check digit, then second check digit.
module cpf_check
  import cpf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  dd_t  in_data_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output logic out_res_o,
  input  logic out_ready_i
);

  logic             v1_q, v2_q, v3_q;
  logic             en1, en2, en3;
  logic [SUM_W-1:0] s1_d, s2_d;
  logic [SUM_W-1:0] s1_q, s2_q, s2p_q, s2p_d;
  logic [3:0]       d1_q, d0_q, d0b_q, c1;
  logic             bad1_q, ok1_q, ok1_d, res_q, res_d;

  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // Base digits sit at positions 2..10, lowest weight on the lowest one.
  always_comb begin
    s1_d = '0;
    s2_d = '0;
    for (int i = 2; i < DIGITS; i++) begin
      s1_d = s1_d + SUM_W'(in_data_i.bcd[4*i +: 4]) * SUM_W'(i);
      s2_d = s2_d + SUM_W'(in_data_i.bcd[4*i +: 4]) * SUM_W'(i + 1);
    end
  end

  assign c1    = exp_digit(s1_q);
  assign ok1_d = !bad1_q && (d1_q == c1);
  assign s2p_d = s2_q + SUM_W'({c1, 1'b0});
  assign res_d = ok1_q && (d0b_q == exp_digit(s2p_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_q   <= s1_d;
      s2_q   <= s2_d;
      d1_q   <= in_data_i.bcd[7:4];
      d0_q   <= in_data_i.bcd[3:0];
      bad1_q <= in_data_i.bad;
    end
    if (en2 && v1_q) begin
      ok1_q <= ok1_d;
      s2p_q <= s2p_d;
      d0b_q <= d0_q;
    end
    if (en3 && v2_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_res_o   = res_q;

  `CPF_ASSERT_NXT(a_bad_fails, clk_i, rst_ni, v1_q && en2 && bad1_q, v2_q && !ok1_q)
  `CPF_ASSERT_NXT(a_first_gate, clk_i, rst_ni, v2_q && en3 && !ok1_q, v3_q && !res_q)
  `CPF_ASSERT_IMP(a_stall_chain, clk_i, rst_ni, !en1, v1_q && v2_q && v3_q)

endmodule

// File: hdl/cpf_check_digit_validator.sv
// CPF check-digit validator: takes an 11-digit taxpayer number as a 37-bit
// binary integer and returns valid_res = 1 when both mod-11 check digits
// (the two lowest decimal digits) match the digits computed from the nine
// base digits; numbers above 99999999999 return 0. One beat is accepted per
// cycle while in_stall_o is low, and one result beat comes out per input
// beat, in order. Each beat passes 37 binary-to-BCD cells (one input bit per
// cell) and 3 check stages (weighted sums, first digit, second digit). Each
// stage holds its beat only while the stage after it is full and stalled, so
// bubbles are squeezed out and input keeps flowing while a result waits.
module cpf_check_digit_validator
  import cpf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [NUM_W-1:0] cpf_number_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             valid_res_o
);

  logic       vld [NUM_W+1];
  logic       rdy [NUM_W+1];
  dd_t        dat [NUM_W+1];

  // Range check up front; the flag rides along with the beat.
  assign vld[0]       = in_valid_i;
  assign dat[0].bad   = cpf_number_i > MAX_VALUE;
  assign dat[0].bcd   = '0;
  assign dat[0].bin   = cpf_number_i;
  assign in_stall_o   = !rdy[0];

  for (genvar k = 0; k < NUM_W; k++) begin : g_cell
    cpf_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (vld[k]),
      .in_data_i   (dat[k]),
      .in_ready_o  (rdy[k]),
      .out_valid_o (vld[k+1]),
      .out_data_o  (dat[k+1]),
      .out_ready_i (rdy[k+1])
    );
  end

  cpf_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld[NUM_W]),
    .in_data_i   (dat[NUM_W]),
    .in_ready_o  (rdy[NUM_W]),
    .out_valid_o (out_valid_o),
    .out_res_o   (valid_res_o),
    .out_ready_i (!out_stall_i)
  );

endmodule
